>>> hdl/fmpf_pkg.sv
package fmpf_pkg;

  localparam int RULE_SLOTS_DEF      = 16;
  localparam int PRIORITY_LEVELS_DEF = 8;

  localparam int IN_BITS  = 192;
  localparam int OUT_BITS = 16;

  typedef enum logic [1:0] {
    ACT_CLASSIFY = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_DELETE   = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    VERD_ACCEPT = 2'd0,
    VERD_SETPRI = 2'd1,
    VERD_REJECT = 2'd2,
    VERD_DROP   = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  priority_v;
    logic [1:0]  verdict;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_mask;
    logic [31:0] dst_addr;
    logic [31:0] src_mask;
    logic [31:0] src_addr;
    logic [8:0]  tos;
    logic [7:0]  protocol;
    logic [3:0]  iface;
    action_t     action;
  } item_t;

  typedef struct packed {
    logic [2:0] new_priority;
    logic       send_reject;
    logic       set_priority;
    logic       drop;
    logic       matched;
    status_t    status;
  } result_t;

endpackage

>>> hdl/fmpf_front.sv
// Input side: hold up to two items for the rule table.
module fmpf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fmpf_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output fmpf_pkg::item_t q_item
);

  fmpf_pkg::item_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
    if (push) buf_r[wr_r] <= in_item;
  end

endmodule

>>> hdl/fmpf_table.sv
// Rule table in age order (slot 0 newest), all slots compared in parallel.
module fmpf_table #(
  parameter int RULE_SLOTS      = fmpf_pkg::RULE_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = fmpf_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  fmpf_pkg::item_t  q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output fmpf_pkg::result_t out_res
);

  localparam int IW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam logic [2:0] PMAX = 3'(PRIORITY_LEVELS - 1);

  fmpf_pkg::item_t rule_r [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] valid_r;

  // stage 1: per-slot hits
  fmpf_pkg::item_t    s1_item_r;
  logic               s1_valid_r;
  logic [RULE_SLOTS-1:0] hit_r, hit_nxt;

  fmpf_pkg::result_t  res_r, res_nxt;
  logic               out_valid_r;
  logic               take, fire;

  // one item in flight: stage 1 then result register
  assign q_ready   = !s1_valid_r && !out_valid_r;
  assign take      = q_valid && q_ready;
  assign fire      = s1_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (q_item.action == fmpf_pkg::ACT_DELETE) begin
        hit_nxt[i] = valid_r[i] &&
          rule_r[i].iface == q_item.iface &&
          rule_r[i].src_addr == q_item.src_addr &&
          rule_r[i].src_mask == q_item.src_mask &&
          rule_r[i].dst_addr == q_item.dst_addr &&
          rule_r[i].dst_mask == q_item.dst_mask &&
          rule_r[i].src_port == q_item.src_port &&
          rule_r[i].dst_port == q_item.dst_port &&
          rule_r[i].tos == q_item.tos;
      end else begin
        hit_nxt[i] = valid_r[i] &&
          (rule_r[i].iface == '0 || rule_r[i].iface == q_item.iface) &&
          (rule_r[i].protocol == '0 || rule_r[i].protocol == q_item.protocol) &&
          (rule_r[i].tos[8] || rule_r[i].tos[7:0] == q_item.tos[7:0]) &&
          (rule_r[i].src_addr == '0 ||
           rule_r[i].src_addr == (rule_r[i].src_mask & q_item.src_addr)) &&
          (rule_r[i].dst_addr == '0 ||
           rule_r[i].dst_addr == (rule_r[i].dst_mask & q_item.dst_addr)) &&
          (rule_r[i].src_port == '0 || rule_r[i].src_port == q_item.src_port) &&
          (rule_r[i].dst_port == '0 || rule_r[i].dst_port == q_item.dst_port);
      end
    end
  end

  // newest hit: lowest set bit
  logic [RULE_SLOTS-1:0] first_oh;
  logic [IW-1:0]         first_idx;
  logic                  any_hit;
  fmpf_pkg::item_t       new_rule;

  always_comb begin
    first_oh  = hit_r & (~hit_r + 1'b1);
    any_hit   = |hit_r;
    first_idx = '0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (first_oh[i]) first_idx = IW'(i);
    end
    new_rule = s1_item_r;
    if (32'(s1_item_r.priority_v) >= 32'(PRIORITY_LEVELS)) new_rule.priority_v = PMAX;

    res_nxt = '0;
    case (s1_item_r.action)
      fmpf_pkg::ACT_ADD: begin
        if (valid_r[RULE_SLOTS-1]) res_nxt.status = fmpf_pkg::ST_FULL;
      end
      fmpf_pkg::ACT_DELETE: begin
        if (!any_hit) res_nxt.status = fmpf_pkg::ST_NOTFOUND;
      end
      fmpf_pkg::ACT_CLASSIFY: begin
        if (any_hit) begin
          res_nxt.matched = 1'b1;
          case (fmpf_pkg::verdict_t'(rule_r[first_idx].verdict))
            fmpf_pkg::VERD_SETPRI: begin
              res_nxt.set_priority = 1'b1;
              res_nxt.new_priority = rule_r[first_idx].priority_v;
            end
            fmpf_pkg::VERD_REJECT: begin
              res_nxt.drop        = 1'b1;
              res_nxt.send_reject = 1'b1;
            end
            fmpf_pkg::VERD_DROP: res_nxt.drop = 1'b1;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // mask from the first hit up: slots at or after the deleted one take the next older rule
  logic [RULE_SLOTS-1:0] after_m;
  always_comb begin
    after_m = ~(first_oh - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= take;
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (fire && s1_item_r.action == fmpf_pkg::ACT_ADD &&
          !valid_r[RULE_SLOTS-1]) begin
        valid_r <= {valid_r[RULE_SLOTS-2:0], 1'b1};
      end else if (fire && s1_item_r.action == fmpf_pkg::ACT_DELETE && any_hit) begin
        valid_r <= (valid_r & ~after_m) | ((valid_r >> 1) & after_m);
      end
    end
    if (take) s1_item_r <= q_item;
    if (take) hit_r <= hit_nxt;
    if (fire) res_r <= res_nxt;
    if (fire && s1_item_r.action == fmpf_pkg::ACT_ADD && !valid_r[RULE_SLOTS-1]) begin
      for (int i = RULE_SLOTS - 1; i > 0; i--) rule_r[i] <= rule_r[i-1];
      rule_r[0] <= new_rule;
    end else if (fire && s1_item_r.action == fmpf_pkg::ACT_DELETE && any_hit) begin
      for (int i = 0; i < RULE_SLOTS - 1; i++) begin
        if (after_m[i]) rule_r[i] <= rule_r[i+1];
      end
    end
  end

endmodule

>>> hdl/first_match_packet_filter.sv
// First-match packet filter. Each item classifies a packet, adds a rule ahead
// of all older ones, deletes the newest rule that matches it on every field
// but protocol, verdict and priority, or does nothing, and returns one result.
// A two-entry input queue feeds the rule table; the table compares every slot
// in parallel and picks the newest hit in the next cycle, registering the hit
// vector and then the result, and takes a new item only once the result of the
// previous one has been handed off.
module first_match_packet_filter #(
  parameter int RULE_SLOTS      = fmpf_pkg::RULE_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = fmpf_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action, iface, protocol, tos, src_addr, src_mask, dst_addr, dst_mask,
  // src_port, dst_port, rule_verdict, rule_priority (from bit 0 up)
  input  logic [fmpf_pkg::IN_BITS-1:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, matched, drop, set_priority, send_reject, new_priority
  output logic [fmpf_pkg::OUT_BITS-1:0] out_tdata
);

  fmpf_pkg::item_t   in_item, q_item;
  fmpf_pkg::result_t res;
  logic q_valid, q_ready;

  assign in_item = fmpf_pkg::item_t'(in_tdata[$bits(fmpf_pkg::item_t)-1:0]);
  assign out_tdata = {7'd0, res.new_priority, res.send_reject, res.set_priority,
                      res.drop, res.matched, res.status};

  fmpf_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  fmpf_table #(.RULE_SLOTS(RULE_SLOTS), .PRIORITY_LEVELS(PRIORITY_LEVELS)) u_table (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

endmodule

>>> hdl/fmpf_checker.sv
module fmpf_checker (
  input logic clk,
  input logic rst_n,
  input logic out_tvalid,
  input logic out_tready,
  input logic [fmpf_pkg::OUT_BITS-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == fmpf_pkg::ST_DONE ||
                    out_tdata[1:0] == fmpf_pkg::ST_NOTFOUND ||
                    out_tdata[1:0] == fmpf_pkg::ST_FULL))
    else $error("bad status");

  a_classify_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != fmpf_pkg::ST_DONE |-> out_tdata[8:2] == 7'd0)
    else $error("verdict bits on table op");

  a_reject_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[3] && !out_tdata[4])
    else $error("reject without drop");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind first_match_packet_filter fmpf_checker u_fmpf_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
